[hw/rtl/crc8fr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8fr_pkg
// Shared constants, types and the CRC-8 byte function of the frame receiver.
// ----------------------------------------------------------------------------
package crc8fr_pkg;

	localparam int FRAME_BYTES   = 27;
	localparam int PAYLOAD_BYTES = 24;
	localparam int WORD_COUNT    = PAYLOAD_BYTES / 2;
	localparam int POS_W         = 6;
	localparam int IDX_W         = 4;

	localparam logic [7:0] CRC_INIT   = 8'hFF;
	localparam logic [7:0] MARK_LOW   = 8'h00;
	localparam logic [7:0] MARK_HIGH  = 8'h80;
	localparam logic [7:0] POLY_RESET = 8'h31;

	typedef enum logic [1:0] {
		ST_CLOSED,
		ST_OPEN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic restart;   // byte opens a new frame
		logic absorb;    // byte goes through the CRC and the store
		logic close;     // rewind position and CRC
		logic rd_start;  // rewind the word read index
		logic rd_en;     // read one word into the output register
	} cmd_t;

	typedef struct packed {
		logic at_last;   // next byte is the received CRC
		logic crc_ok;    // frame check passes on the current byte
		logic out_free;  // output register can take a word
		logic rd_last;   // read index is on the final word
	} status_t;

	// MSB-first CRC-8 over one byte
	function automatic logic [7:0] crc_byte(input logic [7:0] crc,
	                                        input logic [7:0] data,
	                                        input logic [7:0] poly);
		logic [7:0] v;
		v = crc ^ data;
		for (int b = 0; b < 8; b++) begin
			if (v[7]) begin
				v = {v[6:0], 1'b0} ^ poly;
			end else begin
				v = {v[6:0], 1'b0};
			end
		end
		return v;
	endfunction

endpackage

[hw/rtl/crc8fr_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8fr interfaces
// Valid/ready channels for received bytes and decoded words.
// ----------------------------------------------------------------------------
interface crc8fr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_start;

	modport source (output valid, output rx_byte, output frame_start, input ready);
	modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface crc8fr_word_if;
	logic                          valid;
	logic                          ready;
	logic [crc8fr_pkg::IDX_W-1:0]  word_index;
	logic signed [15:0]            word_value;
	logic                          last;

	modport source (output valid, output word_index, output word_value, output last,
	                input ready);
	modport sink   (input valid, input word_index, input word_value, input last,
	                output ready);
endinterface

[hw/rtl/crc8fr_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8fr_dp
// Datapath: byte position, running CRC, markers, payload memory and output.
// ----------------------------------------------------------------------------
module crc8fr_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  crc8fr_pkg::cmd_t              cmd,
	output crc8fr_pkg::status_t           status,
	input  logic [7:0]                    rx_byte,
	input  logic                          cfg_we,
	input  logic [7:0]                    cfg_wdata,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [crc8fr_pkg::IDX_W-1:0]  out_index,
	output logic signed [15:0]            out_value,
	output logic                          out_last
);

	logic [7:0]                   poly_q;
	logic [crc8fr_pkg::POS_W-1:0] pos_q;
	logic [7:0]                   crc_q;
	logic [7:0]                   mark_low_q;
	logic [7:0]                   mark_high_q;
	logic [crc8fr_pkg::IDX_W-1:0] rd_idx_q;
	logic                         out_valid_q;
	logic [crc8fr_pkg::IDX_W-1:0] out_index_q;
	logic [15:0]                  out_value_q;
	logic                         out_last_q;
	logic [15:0]                  mem [crc8fr_pkg::WORD_COUNT];

	logic [crc8fr_pkg::POS_W-1:0] pos_eff;
	logic [7:0]                   crc_eff;
	logic                         store_en;

	assign pos_eff  = cmd.restart ? '0 : pos_q;
	assign crc_eff  = cmd.restart ? crc8fr_pkg::CRC_INIT : crc_q;
	assign store_en = cmd.absorb
		&& (pos_eff < crc8fr_pkg::POS_W'(crc8fr_pkg::PAYLOAD_BYTES));

	assign status.at_last  = pos_q == crc8fr_pkg::POS_W'(crc8fr_pkg::FRAME_BYTES - 1);
	assign status.crc_ok   = (crc_q == rx_byte) && (rx_byte != 8'h00)
		&& (mark_low_q == crc8fr_pkg::MARK_LOW) && (mark_high_q == crc8fr_pkg::MARK_HIGH);
	assign status.out_free = !out_valid_q || out_ready;
	assign status.rd_last  = rd_idx_q == crc8fr_pkg::IDX_W'(crc8fr_pkg::WORD_COUNT - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q      <= crc8fr_pkg::POLY_RESET;
			pos_q       <= '0;
			crc_q       <= crc8fr_pkg::CRC_INIT;
			mark_low_q  <= '0;
			mark_high_q <= '0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				poly_q <= cfg_wdata;
			end
			if (cmd.absorb) begin
				crc_q <= crc8fr_pkg::crc_byte(crc_eff, rx_byte, poly_q);
				pos_q <= pos_eff + 1'b1;
				if (pos_eff == crc8fr_pkg::POS_W'(crc8fr_pkg::FRAME_BYTES - 3)) begin
					mark_low_q <= rx_byte;
				end
				if (pos_eff == crc8fr_pkg::POS_W'(crc8fr_pkg::FRAME_BYTES - 2)) begin
					mark_high_q <= rx_byte;
				end
			end else if (cmd.close) begin
				crc_q <= crc8fr_pkg::CRC_INIT;
				pos_q <= '0;
			end
			if (cmd.rd_start) begin
				rd_idx_q <= '0;
			end else if (cmd.rd_en && !status.rd_last) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (cmd.rd_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload memory: byte writes, one registered word read
	always_ff @(posedge clk) begin
		if (store_en) begin
			if (pos_eff[0]) begin
				mem[pos_eff[crc8fr_pkg::IDX_W:1]][15:8] <= rx_byte;
			end else begin
				mem[pos_eff[crc8fr_pkg::IDX_W:1]][7:0] <= rx_byte;
			end
		end
		if (cmd.rd_en) begin
			out_value_q <= mem[rd_idx_q];
			out_index_q <= rd_idx_q;
			out_last_q  <= status.rd_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_index = out_index_q;
	assign out_value = signed'(out_value_q);
	assign out_last  = out_last_q;

`ifndef SYNTHESIS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < crc8fr_pkg::POS_W'(crc8fr_pkg::FRAME_BYTES))
		else $error("byte position past frame end");

	a_rd_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_idx_q < crc8fr_pkg::IDX_W'(crc8fr_pkg::WORD_COUNT))
		else $error("word read index out of range");

	a_read_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |=> out_valid_q)
		else $error("word read did not reach the output");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_last_q
		|-> out_index_q == crc8fr_pkg::IDX_W'(crc8fr_pkg::WORD_COUNT - 1))
		else $error("last flag on wrong word");
`endif

endmodule

[hw/rtl/crc8fr_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8fr_ctrl
// Frame controller: tracks frame state and sequences the word read-out.
// ----------------------------------------------------------------------------
module crc8fr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_start,
	output logic                in_ready,
	input  crc8fr_pkg::status_t status,
	output crc8fr_pkg::cmd_t    cmd
);

	crc8fr_pkg::state_t state_q;
	crc8fr_pkg::state_t state_d;
	logic               acc;

	assign acc = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crc8fr_pkg::ST_CLOSED;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q) inside
			crc8fr_pkg::ST_CLOSED, crc8fr_pkg::ST_OPEN: begin
				in_ready = 1'b1;
				if (acc && in_start) begin
					cmd.restart = 1'b1;
					cmd.absorb  = 1'b1;
					state_d     = crc8fr_pkg::ST_OPEN;
				end else if (acc && state_q == crc8fr_pkg::ST_OPEN) begin
					if (status.at_last) begin
						cmd.close = 1'b1;
						if (status.crc_ok) begin
							cmd.rd_start = 1'b1;
							state_d      = crc8fr_pkg::ST_EMIT;
						end else begin
							state_d = crc8fr_pkg::ST_CLOSED;
						end
					end else begin
						cmd.absorb = 1'b1;
					end
				end
			end
			crc8fr_pkg::ST_EMIT: begin
				// advance one word each time the output register frees up
				cmd.rd_en = status.out_free;
				if (status.out_free && status.rd_last) begin
					state_d = crc8fr_pkg::ST_CLOSED;
				end
			end
			default: begin
				state_d = crc8fr_pkg::ST_CLOSED;
			end
		endcase
	end

endmodule

[hw/rtl/crc8_frame_receiver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_frame_receiver
// CRC-8 checked frame receiver that emits twelve 16-bit payload words.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while no frame's words are being emitted.
// A passing last byte moves the controller to its emit state, which holds
// input and reads words into the output register, one a cycle while the word
// output does not stall; the first word passes the state and output registers.
// Reset (arst_n low) closes any frame, sets the CRC to 0xFF and the
// polynomial to 0x31; payload memory contents are not cleared.
module crc8_frame_receiver (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [7:0]           cfg_wdata,
	crc8fr_byte_if.sink          rx,
	crc8fr_word_if.source        words
);

	crc8fr_pkg::cmd_t    cmd;
	crc8fr_pkg::status_t status;

	crc8fr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx.valid),
		.in_start (rx.frame_start),
		.in_ready (rx.ready),
		.status   (status),
		.cmd      (cmd)
	);

	crc8fr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.rx_byte   (rx.rx_byte),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_ready (words.ready),
		.out_valid (words.valid),
		.out_index (words.word_index),
		.out_value (words.word_value),
		.out_last  (words.last)
	);

endmodule

[tb/sv/tb_crc8_frame_receiver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crc8_frame_receiver
// Self-checking bench for the CRC-8 frame receiver. Frames of received bytes
// are built with a correct or a broken check, markers or length. A predictor
// in the bench decides which frames pass and queues the twelve payload words
// of each one. The checker compares every word that comes out with the
// oldest queued word. Both handshakes idle at random, and the word output is
// held off for a long stretch once.
// ----------------------------------------------------------------------------
module tb_crc8_frame_receiver;

	localparam int HOLD_CYCLES  = 300;
	localparam int SETTLE       = 20;
	localparam int STALL_LIMIT  = 2000;

	typedef struct {
		logic [crc8fr_pkg::IDX_W-1:0] idx;
		logic signed [15:0]           value;
		logic                         last;
	} word_t;

	typedef enum {
		FR_GOOD,
		FR_BAD_CRC,
		FR_ZERO_CRC,
		FR_BAD_LOW,
		FR_BAD_HIGH
	} frame_kind_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;

	crc8fr_byte_if rx_if ();
	crc8fr_word_if word_if ();

	crc8_frame_receiver i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rx        (rx_if),
		.words     (word_if)
	);

	always #6 clk = ~clk;

	// shadow of the receiver
	logic [7:0] poly_shadow;
	logic       fr_open;
	int         fr_pos;
	logic [7:0] fr_crc;
	logic [7:0] pay_shadow [crc8fr_pkg::PAYLOAD_BYTES];
	logic [7:0] mk_lo;
	logic [7:0] mk_hi;

	word_t      exp_words [$];
	word_t      exp_head;
	logic [7:0] frame_buf [crc8fr_pkg::FRAME_BYTES];

	int src_idle_pct;
	int snk_idle_pct;
	int hold_reqs = 0;
	int hold_done = 0;
	int hold_left = 0;
	int idle_cycles = 0;
	int mismatches = 0;
	int words_checked = 0;
	int words_predicted;
	int frame_bytes;
	int frames_passed;

	function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] data,
	                                           logic [7:0] poly);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb  = crc[7] ^ data[i];
			crc = crc << 1;
			if (fb) begin
				crc = crc ^ poly;
			end
		end
		return crc;
	endfunction

	// advance the shadow by one accepted byte and queue the words it releases
	function automatic void predict_words(logic [7:0] b, logic s);
		word_t w;
		logic  pass;
		if (s) begin
			fr_open = 1'b1;
			fr_pos  = 0;
			fr_crc  = crc8fr_pkg::CRC_INIT;
		end
		if (!fr_open) begin
			return;
		end
		frame_bytes++;
		if (fr_pos < crc8fr_pkg::FRAME_BYTES - 1) begin
			fr_crc = crc8_update(fr_crc, b, poly_shadow);
			if (fr_pos < crc8fr_pkg::PAYLOAD_BYTES) begin
				pay_shadow[fr_pos] = b;
			end
			if (fr_pos == crc8fr_pkg::FRAME_BYTES - 3) begin
				mk_lo = b;
			end
			if (fr_pos == crc8fr_pkg::FRAME_BYTES - 2) begin
				mk_hi = b;
			end
			fr_pos++;
			return;
		end
		pass = (fr_crc == b) && (b != 8'h00) && (mk_lo == crc8fr_pkg::MARK_LOW)
			&& (mk_hi == crc8fr_pkg::MARK_HIGH);
		fr_open = 1'b0;
		fr_pos  = 0;
		fr_crc  = crc8fr_pkg::CRC_INIT;
		if (pass) begin
			frames_passed++;
			for (int k = 0; k < crc8fr_pkg::WORD_COUNT; k++) begin
				w.idx   = k[crc8fr_pkg::IDX_W-1:0];
				w.value = {pay_shadow[2 * k + 1], pay_shadow[2 * k]};
				w.last  = (k == crc8fr_pkg::WORD_COUNT - 1);
				exp_words.push_back(w);
				words_predicted++;
			end
		end
	endfunction

	// receiver side: random idling, or a long hold-off on request
	always @(negedge clk) begin
		if (hold_reqs != hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = hold_reqs;
		end
		if (hold_left > 0) begin
			word_if.ready <= 1'b0;
			hold_left--;
		end else begin
			word_if.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && word_if.valid && word_if.ready) begin
			if (exp_words.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected word idx=%0d value=%0d last=%0b", $time,
				         word_if.word_index, word_if.word_value, word_if.last);
			end else begin
				exp_head = exp_words.pop_front();
				words_checked++;
				if (word_if.word_index !== exp_head.idx ||
				    word_if.word_value !== exp_head.value ||
				    word_if.last !== exp_head.last) begin
					mismatches++;
					$display("%0t: expected idx=%0d value=%0d last=%0b, got idx=%0d value=%0d last=%0b",
					         $time, exp_head.idx, exp_head.value, exp_head.last,
					         word_if.word_index, word_if.word_value, word_if.last);
				end
			end
		end
	end

	// end the run if neither channel moves for too long
	always @(posedge clk) begin
		if ((rx_if.valid && rx_if.ready) || (word_if.valid && word_if.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_byte(logic [7:0] b, logic s);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			rx_if.valid <= 1'b0;
			@(negedge clk);
		end
		rx_if.valid       <= 1'b1;
		rx_if.rx_byte     <= b;
		rx_if.frame_start <= s;
		do begin
			@(posedge clk);
		end while (rx_if.ready !== 1'b1);
		predict_words(b, s);
	endtask

	task automatic push_frame(int n);
		for (int i = 0; i < n; i++) begin
			send_byte(frame_buf[i], i == 0);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		rx_if.valid <= 1'b0;
		while (exp_words.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_poly(logic [7:0] v);
		drain();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we      <= 1'b0;
		poly_shadow = v;
	endtask

	function automatic void fill_payload_random();
		for (int i = 0; i < crc8fr_pkg::FRAME_BYTES; i++) begin
			frame_buf[i] = 8'($urandom_range(255));
		end
	endfunction

	function automatic logic [7:0] frame_crc();
		logic [7:0] c;
		c = crc8fr_pkg::CRC_INIT;
		for (int i = 0; i < crc8fr_pkg::FRAME_BYTES - 1; i++) begin
			c = crc8_update(c, frame_buf[i], poly_shadow);
		end
		return c;
	endfunction

	// set markers and check byte of frame_buf according to the frame kind
	function automatic void seal_frame(frame_kind_t kind);
		logic [7:0] v;
		frame_buf[crc8fr_pkg::FRAME_BYTES - 3] = crc8fr_pkg::MARK_LOW;
		frame_buf[crc8fr_pkg::FRAME_BYTES - 2] = crc8fr_pkg::MARK_HIGH;
		if (kind == FR_BAD_LOW) begin
			frame_buf[crc8fr_pkg::FRAME_BYTES - 3] = 8'($urandom_range(1, 255));
		end
		if (kind == FR_BAD_HIGH) begin
			v = 8'($urandom_range(0, 254));
			if (v >= crc8fr_pkg::MARK_HIGH) begin
				v++;
			end
			frame_buf[crc8fr_pkg::FRAME_BYTES - 2] = v;
		end
		if (kind == FR_ZERO_CRC) begin
			// steer the last payload byte until the check comes out zero
			for (int t = 0; t < 256; t++) begin
				frame_buf[crc8fr_pkg::PAYLOAD_BYTES - 1] = t[7:0];
				if (frame_crc() == 8'h00) begin
					break;
				end
			end
		end
		frame_buf[crc8fr_pkg::FRAME_BYTES - 1] = frame_crc();
		if (kind == FR_BAD_CRC) begin
			frame_buf[crc8fr_pkg::FRAME_BYTES - 1] ^= 8'($urandom_range(1, 255));
		end
	endfunction

	task automatic test_word_extremes();
		logic [7:0] head [8] = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'hFF, 8'h7F};
		fill_payload_random();
		foreach (head[i]) begin
			frame_buf[i] = head[i];
		end
		seal_frame(FR_GOOD);
		push_frame(crc8fr_pkg::FRAME_BYTES);
		drain();
	endtask

	task automatic test_rejections();
		frame_kind_t kinds [4] = '{FR_BAD_CRC, FR_ZERO_CRC, FR_BAD_LOW, FR_BAD_HIGH};
		foreach (kinds[i]) begin
			fill_payload_random();
			seal_frame(kinds[i]);
			push_frame(crc8fr_pkg::FRAME_BYTES);
		end
		drain();
	endtask

	task automatic test_framing();
		// stray bytes before any start are dropped
		send_byte(8'h5A, 1'b0);
		send_byte(8'hA5, 1'b0);
		// a start in the middle of a frame abandons it
		fill_payload_random();
		seal_frame(FR_GOOD);
		push_frame(6);
		push_frame(crc8fr_pkg::FRAME_BYTES);
		// trailing bytes after a closed frame are dropped
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		drain();
	endtask

	task automatic test_output_holdoff();
		set_poly(8'h07);
		hold_reqs++;
		repeat (2) begin
			fill_payload_random();
			seal_frame(FR_GOOD);
			push_frame(crc8fr_pkg::FRAME_BYTES);
		end
		drain();
	endtask

	task automatic test_random_traffic(int src_pct, int snk_pct, logic [7:0] poly, int budget);
		int bytes0;
		int words0;
		int pick;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		set_poly(poly);
		bytes0 = frame_bytes;
		words0 = words_predicted;
		while (frame_bytes - bytes0 < budget
		       || words_predicted - words0 < crc8fr_pkg::WORD_COUNT) begin
			pick = $urandom_range(99);
			fill_payload_random();
			if (pick < 60) begin
				seal_frame(FR_GOOD);
				push_frame(crc8fr_pkg::FRAME_BYTES);
			end else if (pick < 68) begin
				seal_frame(FR_BAD_CRC);
				push_frame(crc8fr_pkg::FRAME_BYTES);
			end else if (pick < 72) begin
				seal_frame(FR_BAD_LOW);
				push_frame(crc8fr_pkg::FRAME_BYTES);
			end else if (pick < 76) begin
				seal_frame(FR_BAD_HIGH);
				push_frame(crc8fr_pkg::FRAME_BYTES);
			end else if (pick < 78) begin
				seal_frame(FR_ZERO_CRC);
				push_frame(crc8fr_pkg::FRAME_BYTES);
			end else if (pick < 90) begin
				seal_frame(FR_GOOD);
				push_frame($urandom_range(1, crc8fr_pkg::FRAME_BYTES - 1));
			end else begin
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)), 1'b0);
			end
		end
		drain();
	endtask

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = 8'h00;
		rx_if.valid       = 1'b0;
		rx_if.rx_byte     = 8'h00;
		rx_if.frame_start = 1'b0;
		poly_shadow       = crc8fr_pkg::POLY_RESET;
		fr_open           = 1'b0;
		fr_pos            = 0;
		fr_crc            = crc8fr_pkg::CRC_INIT;
		mk_lo             = 8'h00;
		mk_hi             = 8'h00;
		words_predicted   = 0;
		frame_bytes       = 0;
		frames_passed     = 0;
		src_idle_pct      = 17;
		snk_idle_pct      = 87;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_word_extremes();
		test_rejections();
		test_framing();
		test_random_traffic(87, 17, 8'($urandom_range(0, 127) * 2 + 1), 20);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		test_output_holdoff();

		$display("Covered %0d frame bytes, %0d passing frames, %0d words checked,",
		         frame_bytes, frames_passed, words_checked);
		$display("over three polynomials, both idle patterns and a long output hold-off.");
		if (mismatches == 0 && exp_words.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
